// File: sv/slwm_pkg.sv
// Shared types and constants for the SQL LIKE wildcard matcher.
// No dependencies; used by slwm_core and the top level by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package slwm_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int CFG_LEN_W   = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;

    localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;
    localparam logic [BYTE_W-1:0] ONE_CHAR = 8'h5F;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD0  = 3'd1,
        REG_PATTERN_WORD1  = 3'd2,
        REG_PATTERN_WORD2  = 3'd3,
        REG_PATTERN_WORD3  = 3'd4
    } cfg_index_t;

endpackage

`default_nettype wire

// File: sv/slwm_closure.sv
// Zero-width skip closure: a parallel-prefix OR over the position vector.
// Depends on nothing; instanced by slwm_core.
`timescale 1ns / 1ps
`default_nettype none

module slwm_closure #(
    parameter int WIDTH = 33
) (
    input  wire logic [WIDTH-1:0] act,
    input  wire logic [WIDTH-2:0] prop,
    output logic      [WIDTH-1:0] closed
);

    localparam int LEVELS = $clog2(WIDTH);

    logic [WIDTH-1:0] g_lvl [LEVELS+1];
    logic [WIDTH-1:0] p_lvl [LEVELS+1];

    always_comb
    begin
        g_lvl[0] = act;
        p_lvl[0] = {prop, 1'b0};
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int j = 0; j < WIDTH; j++)
            begin
                if (j >= (1 << l))
                begin
                    g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j-(1<<l)]);
                    p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j-(1<<l)];
                end
                else
                begin
                    g_lvl[l+1][j] = g_lvl[l][j];
                    p_lvl[l+1][j] = 1'b0;
                end
            end
        end
    end

    assign closed = g_lvl[LEVELS];

endmodule

`default_nettype wire

// File: sv/slwm_core.sv
// Per-byte update: close, advance to next_state, close, pick the match bit.
// Depends on slwm_pkg and slwm_closure.
`timescale 1ns / 1ps
`default_nettype none

module slwm_core #(
    parameter int PATTERN_BYTES = 32
) (
    input  wire logic [PATTERN_BYTES:0]                     state,
    input  wire logic [PATTERN_BYTES*slwm_pkg::BYTE_W-1:0]  pattern,
    input  wire logic [$clog2(PATTERN_BYTES+1)-1:0]         len_used,
    input  wire logic [slwm_pkg::BYTE_W-1:0]                subject_byte,
    input  wire logic                                       empty_subject,
    output logic      [PATTERN_BYTES:0]                     next_state,
    output logic                                            matched
);

    localparam int N     = PATTERN_BYTES;
    localparam int LEN_W = $clog2(PATTERN_BYTES+1);

    logic [N-1:0] en;
    logic [N-1:0] pct;
    logic [N-1:0] mv;
    logic [N-1:0] prop;
    logic [N:0]   base;
    logic [N:0]   a1;
    logic [N:0]   a2;
    logic [N:0]   a3;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            en[i]  = LEN_W'(i) < len_used;
            pct[i] = pattern[i*slwm_pkg::BYTE_W +: slwm_pkg::BYTE_W] == slwm_pkg::PCT_CHAR;
            mv[i]  = !pct[i]
                   && ((pattern[i*slwm_pkg::BYTE_W +: slwm_pkg::BYTE_W] == slwm_pkg::ONE_CHAR)
                   || (pattern[i*slwm_pkg::BYTE_W +: slwm_pkg::BYTE_W] == subject_byte));
        end
    end

    assign prop = pct & en;
    assign base = empty_subject ? {{N{1'b0}}, 1'b1} : state;

    slwm_closure #(.WIDTH(N+1)) u_close_pre (
        .act    (base),
        .prop   (prop),
        .closed (a1)
    );

    assign a2 = {1'b0, a1[N-1:0] & en & pct} | {a1[N-1:0] & en & mv, 1'b0};

    slwm_closure #(.WIDTH(N+1)) u_close_post (
        .act    (a2),
        .prop   (prop),
        .closed (a3)
    );

    assign next_state = a2;
    assign matched    = empty_subject ? a1[len_used] : a3[len_used];

endmodule

`default_nettype wire

// File: sv/sql_like_wildcard_matcher.sv
// SQL LIKE matcher top level: config registers, input register, state, result register.
// Result path: a last or empty item is held in the input register, and its match bit
// is written into the result register when that item fires.
// Throughput: one item per cycle; a last or empty item holds while the result register
// is full and m_axis_tready is low.
// Reset: only the start position active, pattern length and words cleared, no item held.
// Depends on slwm_pkg and slwm_core.
`timescale 1ns / 1ps
`default_nettype none

module sql_like_wildcard_matcher #(
    parameter int PATTERN_BYTES = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [slwm_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [7:0] subject_byte
    input  wire logic                                s_axis_tlast,
    input  wire logic [0:0]                          s_axis_tuser,   // [0] empty_subject
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [slwm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,   // [0] matched, [7:1] zero
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [slwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [slwm_pkg::WORD_W-1:0]         cfg_data
);

    localparam int N     = PATTERN_BYTES;
    localparam int LEN_W = $clog2(PATTERN_BYTES+1);

    logic [slwm_pkg::CFG_LEN_W-1:0] pattern_length_reg;
    logic [slwm_pkg::WORD_W-1:0]    pattern_word0_reg;
    logic [slwm_pkg::WORD_W-1:0]    pattern_word1_reg;
    logic [slwm_pkg::WORD_W-1:0]    pattern_word2_reg;
    logic [slwm_pkg::WORD_W-1:0]    pattern_word3_reg;

    logic                           in_valid_reg;
    logic [slwm_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                           in_last_reg;
    logic                           in_empty_reg;
    logic [N:0]                     state_reg;
    logic [N:0]                     state_next;
    logic                           out_valid_reg;
    logic                           out_matched_reg;

    logic [4*slwm_pkg::WORD_W-1:0]  all_words;
    logic [LEN_W-1:0]               len_used;
    logic                           produces;
    logic                           fire;
    logic                           core_matched;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_word0_reg  <= '0;
            pattern_word1_reg  <= '0;
            pattern_word2_reg  <= '0;
            pattern_word3_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                slwm_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[slwm_pkg::CFG_LEN_W-1:0];
                slwm_pkg::REG_PATTERN_WORD0: pattern_word0_reg <= cfg_data;
                slwm_pkg::REG_PATTERN_WORD1: pattern_word1_reg <= cfg_data;
                slwm_pkg::REG_PATTERN_WORD2: pattern_word2_reg <= cfg_data;
                slwm_pkg::REG_PATTERN_WORD3: pattern_word3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign all_words = {pattern_word3_reg, pattern_word2_reg, pattern_word1_reg,
                        pattern_word0_reg};
    assign len_used  = (pattern_length_reg > slwm_pkg::CFG_LEN_W'(PATTERN_BYTES))
                     ? LEN_W'(PATTERN_BYTES)
                     : pattern_length_reg[LEN_W-1:0];

    assign produces      = in_last_reg | in_empty_reg;
    assign fire          = in_valid_reg & (!produces | !out_valid_reg | m_axis_tready);
    assign s_axis_tready = !in_valid_reg | fire;

    slwm_core #(.PATTERN_BYTES(N)) u_core (
        .state         (state_reg),
        .pattern       (all_words[N*slwm_pkg::BYTE_W-1:0]),
        .len_used      (len_used),
        .subject_byte  (in_byte_reg),
        .empty_subject (in_empty_reg),
        .next_state    (state_next),
        .matched       (core_matched)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= {{N{1'b0}}, 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (fire)
                state_reg <= produces ? {{N{1'b0}}, 1'b1} : state_next;
            if (fire && produces)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata[slwm_pkg::BYTE_W-1:0];
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser[0];
        end
        if (fire && produces)
            out_matched_reg <= core_matched;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(slwm_pkg::TDATA_OUT_W-1){1'b0}}, out_matched_reg};

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && produces |=> state_reg == {{N{1'b0}}, 1'b1})
        else $error("state not back at start after a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !(fire && produces))
        else $error("pending result overwritten");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        fire && produces |=> m_axis_tvalid)
        else $error("result not presented");

endmodule

`default_nettype wire
